[rtl/rmn_pkg.sv]
// roman numeral encoder package: types, constants and letter tables
// no dependencies; used by every module of the encoder
`timescale 1ns / 1ps

package rmn_pkg;

  localparam int NUM_BITS    = 12;
  localparam int SYM_BITS    = 7;
  localparam int NUM_DIGITS  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [NUM_BITS-1:0] MAX_VALID = 12'd3999;

  localparam logic [SYM_BITS-1:0] SYM_NONE = 7'h00;
  localparam logic [SYM_BITS-1:0] SYM_I    = 7'h49;
  localparam logic [SYM_BITS-1:0] SYM_V    = 7'h56;
  localparam logic [SYM_BITS-1:0] SYM_X    = 7'h58;
  localparam logic [SYM_BITS-1:0] SYM_L    = 7'h4C;
  localparam logic [SYM_BITS-1:0] SYM_C    = 7'h43;
  localparam logic [SYM_BITS-1:0] SYM_D    = 7'h44;
  localparam logic [SYM_BITS-1:0] SYM_M    = 7'h4D;

  // decimal positions, ones to thousands
  localparam logic [1:0] POS_ONES      = 2'd0;
  localparam logic [1:0] POS_TENS      = 2'd1;
  localparam logic [1:0] POS_HUNDREDS  = 2'd2;
  localparam logic [1:0] POS_THOUSANDS = 2'd3;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic                       invalid;
    logic [NUM_DIGITS-1:0][3:0] digits;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    LC_ONE,
    LC_FIVE,
    LC_TEN
  } letter_code_t;

  // letters used by one decimal digit
  function automatic logic [2:0] dig_len(input digit_t d);
    logic [2:0] len;
    case (d)
      4'd1, 4'd5:              len = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9:  len = 3'd2;
      4'd3, 4'd7:              len = 3'd3;
      4'd8:                    len = 3'd4;
      default:                 len = 3'd0;
    endcase
    return len;
  endfunction

  // which of one, five or ten stands at a place within a digit's letters
  function automatic letter_code_t dig_code(input digit_t d, input logic [1:0] idx);
    letter_code_t c;
    case (d)
      4'd1, 4'd2, 4'd3:  c = LC_ONE;
      4'd4:              c = (idx == 2'd0) ? LC_ONE : LC_FIVE;
      4'd5:              c = LC_FIVE;
      4'd6, 4'd7, 4'd8:  c = (idx == 2'd0) ? LC_FIVE : LC_ONE;
      4'd9:              c = (idx == 2'd0) ? LC_ONE : LC_TEN;
      default:           c = LC_ONE;
    endcase
    return c;
  endfunction

  function automatic logic [SYM_BITS-1:0] letter_sym(input logic [1:0] pos,
                                                     input letter_code_t c);
    logic [SYM_BITS-1:0] s;
    s = SYM_NONE;
    case (pos)
      POS_ONES: begin
        case (c)
          LC_ONE:  s = SYM_I;
          LC_FIVE: s = SYM_V;
          LC_TEN:  s = SYM_X;
          default: s = SYM_NONE;
        endcase
      end
      POS_TENS: begin
        case (c)
          LC_ONE:  s = SYM_X;
          LC_FIVE: s = SYM_L;
          LC_TEN:  s = SYM_C;
          default: s = SYM_NONE;
        endcase
      end
      POS_HUNDREDS: begin
        case (c)
          LC_ONE:  s = SYM_C;
          LC_FIVE: s = SYM_D;
          LC_TEN:  s = SYM_M;
          default: s = SYM_NONE;
        endcase
      end
      default: begin
        case (c)
          LC_ONE:  s = SYM_M;
          default: s = SYM_NONE;
        endcase
      end
    endcase
    return s;
  endfunction

endpackage

[rtl/rmn_front.sv]
// front end: takes a number, range checks it and converts it to four bcd digits
// serial shift-add-3 conversion, one bit per cycle; depends on rmn_pkg
`timescale 1ns / 1ps

module rmn_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rmn_pkg::NUM_BITS-1:0] in_number,
  input  rmn_pkg::q_status_t           q_status,
  output logic                         busy,
  output logic                         push,
  output rmn_pkg::entry_t              push_entry
);
  import rmn_pkg::*;

  localparam int CNT_W = $clog2(NUM_BITS);
  localparam int BCD_W = 4 * NUM_DIGITS;

  front_state_t        state_r, state_nxt;
  logic [NUM_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                inv_r, inv_nxt;
  logic                accept;
  logic                conv_done;
  logic [BCD_W-1:0]    bcd_adj;

  assign accept    = start && (state_r == FS_IDLE);
  assign conv_done = (cnt_r == CNT_W'(NUM_BITS - 1));

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: begin
        if (accept) begin
          if ((in_number == '0) || (in_number > MAX_VALID)) begin
            state_nxt = FS_PUSH;
          end else begin
            state_nxt = FS_CONV;
          end
        end
      end
      FS_CONV: begin
        if (conv_done) begin
          state_nxt = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!q_status.full) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    push = 1'b0;
    case (state_r)
      FS_IDLE: busy = 1'b0;
      FS_CONV: busy = 1'b1;
      FS_PUSH: push = !q_status.full;
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    inv_nxt = inv_r;
    if (accept) begin
      bin_nxt = in_number;
      bcd_nxt = '0;
      cnt_nxt = '0;
      inv_nxt = (in_number == '0) || (in_number > MAX_VALID);
    end else if (state_r == FS_CONV) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[NUM_BITS-1]};
      bin_nxt = {bin_r[NUM_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign push_entry.invalid = inv_r;
  assign push_entry.digits  = bcd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    inv_r <= inv_nxt;
  end

endmodule

[rtl/rmn_fifo.sv]
// short queue of converted numbers between front end and letter emitter
// depends on rmn_pkg
`timescale 1ns / 1ps

module rmn_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rmn_pkg::entry_t    push_entry,
  input  logic               pop,
  output rmn_pkg::q_status_t q_status,
  output rmn_pkg::entry_t    head
);
  import rmn_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign q_status.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (cnt_r == '0);
  assign do_wr = push && !q_status.full;
  assign do_rd = pop && !q_status.empty;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/rmn_back.sv]
// letter emitter: walks queued digits from thousands down, one letter per cycle while
// the queue holds an entry, none on a zero digit; depends on rmn_pkg letter tables
`timescale 1ns / 1ps

module rmn_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rmn_pkg::q_status_t           q_status,
  input  rmn_pkg::entry_t              head,
  output logic                         pop,
  output logic                         out_valid,
  output logic [rmn_pkg::SYM_BITS-1:0] out_symbol,
  output logic                         out_last,
  output logic                         out_invalid
);
  import rmn_pkg::*;

  logic [1:0]          pos_r, pos_nxt;
  logic [1:0]          let_r, let_nxt;
  logic                valid_r, valid_nxt;
  logic [SYM_BITS-1:0] sym_r, sym_nxt;
  logic                last_r, last_nxt;
  logic                inv_r, inv_nxt;
  digit_t              cur_digit;
  logic [2:0]          cur_len;
  letter_code_t        cur_code;
  logic                digit_end;
  logic                lower_zero;

  assign cur_digit = head.digits[pos_r];
  assign cur_len   = dig_len(cur_digit);
  assign cur_code  = dig_code(cur_digit, let_r);
  assign digit_end = ((3'(let_r) + 3'd1) == cur_len);

  always_comb begin
    case (pos_r)
      POS_THOUSANDS: lower_zero = (head.digits[2:0] == '0);
      POS_HUNDREDS:  lower_zero = (head.digits[1:0] == '0);
      POS_TENS:      lower_zero = (head.digits[0] == '0);
      default:       lower_zero = 1'b1;
    endcase
  end

  always_comb begin
    pos_nxt   = pos_r;
    let_nxt   = let_r;
    pop       = 1'b0;
    valid_nxt = 1'b0;
    sym_nxt   = sym_r;
    last_nxt  = last_r;
    inv_nxt   = inv_r;
    if (!q_status.empty) begin
      if (head.invalid) begin
        valid_nxt = 1'b1;
        sym_nxt   = SYM_NONE;
        last_nxt  = 1'b1;
        inv_nxt   = 1'b1;
        pop       = 1'b1;
        pos_nxt   = POS_THOUSANDS;
        let_nxt   = 2'd0;
      end else if (cur_len == 3'd0) begin
        // zero digit has no letters
        pos_nxt = pos_r - 2'd1;
        let_nxt = 2'd0;
      end else begin
        valid_nxt = 1'b1;
        sym_nxt   = letter_sym(pos_r, cur_code);
        last_nxt  = digit_end && lower_zero;
        inv_nxt   = 1'b0;
        if (digit_end && lower_zero) begin
          pop     = 1'b1;
          pos_nxt = POS_THOUSANDS;
          let_nxt = 2'd0;
        end else if (digit_end) begin
          pos_nxt = pos_r - 2'd1;
          let_nxt = 2'd0;
        end else begin
          let_nxt = let_r + 2'd1;
        end
      end
    end
  end

  assign out_valid   = valid_r;
  assign out_symbol  = sym_r;
  assign out_last    = last_r;
  assign out_invalid = inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_THOUSANDS;
      let_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      let_r   <= let_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
    inv_r  <= inv_nxt;
  end

endmodule

[rtl/integer_to_roman_encoder.sv]
// top level of the roman numeral encoder: front end, queue and letter emitter
// depends on rmn_pkg, rmn_front, rmn_fifo, rmn_back
//
//   channel   ports                                     handshake
//   input     in_number[11:0]                           start, busy
//   result    out_symbol[6:0], out_last, out_invalid    out_valid strobe
//
// the front end accepts a number while idle, converts it from binary to bcd bit-serially
// and then enters it into the two-entry queue once the queue has room; an out-of-range
// number skips the conversion; the emitter sends one letter per cycle while the queue
// holds an entry and steps over each zero digit above the last letter without a letter
// a new number waits until the last one is queued, not until its letters are sent
// reset is synchronous, active low, and empties the queue
// results cannot be held off; busy stays high while the front end waits on a full queue
`timescale 1ns / 1ps

module integer_to_roman_encoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rmn_pkg::NUM_BITS-1:0] in_number,
  output logic                         out_valid,
  output logic [rmn_pkg::SYM_BITS-1:0] out_symbol,
  output logic                         out_last,
  output logic                         out_invalid
);
  import rmn_pkg::*;

  q_status_t q_status;
  entry_t    push_entry;
  entry_t    head;
  logic      push;
  logic      pop;

  rmn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_number  (in_number),
    .q_status   (q_status),
    .busy       (busy),
    .push       (push),
    .push_entry (push_entry)
  );

  rmn_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_status   (q_status),
    .head       (head)
  );

  rmn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_symbol  (out_symbol),
    .out_last    (out_last),
    .out_invalid (out_invalid)
  );

`ifndef SYNTHESIS
  a_invalid_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_last && (out_symbol == SYM_NONE))
    else $error("invalid request not a single empty result");

  a_letter_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |-> (out_symbol != SYM_NONE))
    else $error("valid letter with empty symbol");

  a_busy_after_start : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("front end not busy after accepting a request");

  a_pop_only_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");
`endif

endmodule
